/* src/oad_pkg.sv */
// Package for the object identifier arc decoder: field widths, constants,
// result status codes and the entry type passed from the front end to the back end.
// No dependencies.
`default_nettype none

package oad_pkg;

  localparam int ARC_FIELD_W  = 32;
  localparam int ARC_BITS_DEF = 32;
  localparam int BYTE_W       = 8;
  localparam int DIGIT_W      = 7;
  localparam int CONT_BIT     = 7;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [ARC_FIELD_W-1:0] SPLIT_ISO   = ARC_FIELD_W'(40);
  localparam logic [ARC_FIELD_W-1:0] SPLIT_JOINT = ARC_FIELD_W'(80);
  localparam logic [ARC_FIELD_W-1:0] ROOT_ITU    = ARC_FIELD_W'(0);
  localparam logic [ARC_FIELD_W-1:0] ROOT_ISO    = ARC_FIELD_W'(1);
  localparam logic [ARC_FIELD_W-1:0] ROOT_JOINT  = ARC_FIELD_W'(2);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ENT_ARC,
    ENT_FIRST,
    ENT_TRUNC
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t              kind;
    logic [ARC_FIELD_W-1:0]   value;
    logic                     ovf;
    logic                     fin;
  } entry_t;

endpackage

`default_nettype wire

/* src/oad_if.sv */
// Valid/ready channel interfaces for the arc decoder: content bytes in, arcs out.
// Depends on nothing; field widths follow the block's fixed item format.
`default_nettype none

interface oad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] content_byte;
  logic       final_byte;

  modport source (output valid, output content_byte, output final_byte, input ready);
  modport sink   (input valid, input content_byte, input final_byte, output ready);
endinterface

interface oad_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] arc_value;
  logic        run_last;
  logic        identifier_end;
  logic [1:0]  status;

  modport source (output valid, output arc_value, output run_last,
                  output identifier_end, output status, input ready);
  modport sink   (input valid, input arc_value, input run_last,
                  input identifier_end, input status, output ready);
endinterface

`default_nettype wire

/* src/oad_front.sv */
// Front end of the arc decoder: accepts content bytes, accumulates base-128 digits
// and pushes one classified entry per completed subidentifier. Uses oad_pkg, oad_if.
`default_nettype none

module oad_front #(
  parameter int ARC_BITS = oad_pkg::ARC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  oad_in_if.sink              in_ch,
  output logic                push_valid,
  input  wire logic           push_ready,
  output oad_pkg::entry_t     push_entry
);
  import oad_pkg::*;

  localparam int AW = (ARC_BITS < ARC_FIELD_W) ? ARC_BITS : ARC_FIELD_W;

  logic [AW-1:0] acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;
  logic          first_r, first_nxt;
  logic          cont;
  logic          fire;
  logic          sum_ovf;
  logic [AW-1:0] sum;

  assign cont        = in_ch.content_byte[CONT_BIT];
  assign in_ch.ready = push_ready;
  assign fire        = in_ch.valid && push_ready;
  assign sum_ovf     = ovf_r || (|acc_r[AW-1 -: DIGIT_W]);
  assign sum         = sum_ovf ? '1
                     : {acc_r[AW-DIGIT_W-1:0], in_ch.content_byte[DIGIT_W-1:0]};

  always_comb begin
    acc_nxt          = acc_r;
    ovf_nxt          = ovf_r;
    first_nxt        = first_r;
    push_valid       = 1'b0;
    push_entry.kind  = ENT_ARC;
    push_entry.value = ARC_FIELD_W'(sum);
    push_entry.ovf   = sum_ovf;
    push_entry.fin   = in_ch.final_byte;
    if (fire) begin
      if (cont && in_ch.final_byte) begin
        push_valid      = 1'b1;
        push_entry.kind = ENT_TRUNC;
        acc_nxt         = '0;
        ovf_nxt         = 1'b0;
        first_nxt       = 1'b1;
      end else if (cont) begin
        acc_nxt = sum;
        ovf_nxt = sum_ovf;
      end else begin
        push_valid      = 1'b1;
        push_entry.kind = first_r ? ENT_FIRST : ENT_ARC;
        acc_nxt         = '0;
        ovf_nxt         = 1'b0;
        first_nxt       = in_ch.final_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      first_r <= 1'b1;
    end else begin
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      first_r <= first_nxt;
    end
  end

  // A final byte always leaves the decoder ready for a fresh identifier.
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_ch.final_byte |=> first_r && !ovf_r && (acc_r == '0))
    else $error("state not cleared after final byte");

endmodule

`default_nettype wire

/* src/oad_queue.sv */
// Two-entry queue between the front and back ends of the arc decoder.
// Uses oad_pkg for the entry type and depth.
`default_nettype none

module oad_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire oad_pkg::entry_t  push_entry,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output oad_pkg::entry_t       pop_entry
);
  import oad_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

  entry_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* src/oad_back.sv */
// Back end of the arc decoder: turns queue entries into arc results, splitting the
// first subidentifier into two arcs, behind an output register. Uses oad_pkg, oad_if.
`default_nettype none

module oad_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire oad_pkg::entry_t  pop_entry,
  oad_out_if.source             out_ch
);
  import oad_pkg::*;

  logic                   out_valid_r, out_valid_nxt;
  logic [ARC_FIELD_W-1:0] out_arc_r, out_arc_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_end_r, out_end_nxt;
  status_t                out_status_r, out_status_nxt;
  logic                   pend_r, pend_nxt;
  logic [ARC_FIELD_W-1:0] pend_arc_r, pend_arc_nxt;
  logic                   pend_end_r, pend_end_nxt;
  status_t                pend_status_r, pend_status_nxt;

  logic                   out_free;
  logic [ARC_FIELD_W-1:0] root_arc, rest_arc;
  logic [ARC_FIELD_W-1:0] d_arc;
  logic                   d_last, d_end, d_pend;
  status_t                d_status, arc_status;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign pop_ready = out_free && !pend_r;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.arc_value      = out_arc_r;
  assign out_ch.run_last       = out_last_r;
  assign out_ch.identifier_end = out_end_r;
  assign out_ch.status         = out_status_r;

  assign arc_status = pop_entry.ovf ? ST_OVERFLOW : ST_OK;

  always_comb begin
    if (pop_entry.ovf) begin
      root_arc = ROOT_JOINT;
      rest_arc = pop_entry.value;
    end else if (pop_entry.value < SPLIT_ISO) begin
      root_arc = ROOT_ITU;
      rest_arc = pop_entry.value;
    end else if (pop_entry.value < SPLIT_JOINT) begin
      root_arc = ROOT_ISO;
      rest_arc = pop_entry.value - SPLIT_ISO;
    end else begin
      root_arc = ROOT_JOINT;
      rest_arc = pop_entry.value - SPLIT_JOINT;
    end
  end

  always_comb begin
    d_arc    = pop_entry.value;
    d_last   = 1'b1;
    d_end    = pop_entry.fin;
    d_status = arc_status;
    d_pend   = 1'b0;
    case (pop_entry.kind)
      ENT_TRUNC: begin
        d_arc    = '0;
        d_end    = 1'b1;
        d_status = ST_TRUNCATED;
      end
      ENT_FIRST: begin
        d_arc    = root_arc;
        d_last   = 1'b0;
        d_end    = 1'b0;
        d_status = ST_OK;
        d_pend   = 1'b1;
      end
      default: begin
        d_arc = pop_entry.value;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_arc_nxt     = out_arc_r;
    out_last_nxt    = out_last_r;
    out_end_nxt     = out_end_r;
    out_status_nxt  = out_status_r;
    pend_nxt        = pend_r;
    pend_arc_nxt    = pend_arc_r;
    pend_end_nxt    = pend_end_r;
    pend_status_nxt = pend_status_r;
    if (out_free) begin
      if (pend_r) begin
        out_valid_nxt  = 1'b1;
        out_arc_nxt    = pend_arc_r;
        out_last_nxt   = 1'b1;
        out_end_nxt    = pend_end_r;
        out_status_nxt = pend_status_r;
        pend_nxt       = 1'b0;
      end else if (pop_valid) begin
        out_valid_nxt   = 1'b1;
        out_arc_nxt     = d_arc;
        out_last_nxt    = d_last;
        out_end_nxt     = d_end;
        out_status_nxt  = d_status;
        pend_nxt        = d_pend;
        pend_arc_nxt    = rest_arc;
        pend_end_nxt    = pop_entry.fin;
        pend_status_nxt = arc_status;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_arc_r     <= out_arc_nxt;
    out_last_r    <= out_last_nxt;
    out_end_r     <= out_end_nxt;
    out_status_r  <= out_status_nxt;
    pend_arc_r    <= pend_arc_nxt;
    pend_end_r    <= pend_end_nxt;
    pend_status_r <= pend_status_nxt;
  end

  // The second arc of a split is only held while the first one is on the port.
  a_pend_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("pending second arc without a shown first arc");

  // A result that is not the last of its byte always has its partner waiting.
  a_not_last_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> pend_r)
    else $error("first arc shown without a pending second arc");

  a_trunc_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_TRUNCATED) |-> out_end_r && out_last_r)
    else $error("truncated result does not end the identifier");

endmodule

`default_nettype wire

/* src/oid_arc_decoder_core.sv */
// Object identifier arc decoder, top level: front end, entry queue and back end.
// Depends on oad_pkg, oad_if, oad_front, oad_queue and oad_back.
//
// Usage: in_ch carries one content byte of an object identifier per transfer,
// with final_byte set on the identifier's last byte. out_ch carries the decoded
// arcs. A byte that completes a subidentifier gives one arc; the first
// subidentifier of an identifier gives two (the root arc, then the remainder).
// A final byte with the continuation bit set gives one truncated result.
// A result passes from its byte's transfer through a queue slot into the output
// register, from which out_ch takes it. Throughput: one byte per cycle while
// out_ch takes results and each byte gives at most one result. The output
// register moves one result per cycle, so a doubled first-arc result stops the
// back end popping until its second arc is loaded, which can drop in_ch.ready in
// a back-to-back stream; bytes that each give two results run at the output rate.
// When out_ch stalls, the output register holds its result, the queue fills and
// in_ch.ready falls once both queue entries are taken.
// Reset (synchronous, active low) empties the queue and output register and
// starts a new identifier.
`default_nettype none

module oid_arc_decoder_core #(
  parameter int ARC_BITS = oad_pkg::ARC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  oad_in_if.sink     in_ch,
  oad_out_if.source  out_ch
);
  import oad_pkg::*;

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  oad_front #(
    .ARC_BITS (ARC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  oad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  oad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
